// File: hw/rtl/cfb_pkg.sv
// shared types, constants and crc step function for the command frame builder
// no dependencies; imported by every module of the block
package cfb_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned FRAME_LEN   = 6;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_BYTE  = 2'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;
    localparam logic [BYTE_W-1:0] STOP_BYTE_RESET  = 8'h03;
    localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] payload_byte;
    } cfb_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_last;
    } cfb_result_t;

    // one queued command with its checksum
    typedef struct packed {
        logic [BYTE_W-1:0] command_byte;
        logic [BYTE_W-1:0] payload_byte;
        logic [CRC_W-1:0]  crc;
    } cfb_entry_t;

    // crc-16/ccitt-false, one byte per call
    function automatic logic [CRC_W-1:0] crc_add_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] x;
        logic [CRC_W-1:0]  xw;
        x  = crc[CRC_W-1 -: BYTE_W] ^ b;
        x  = x ^ (x >> 4);
        xw = {{(CRC_W-BYTE_W){1'b0}}, x};
        return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
    endfunction

endpackage

// File: hw/rtl/cfb_front.sv
// front stage: accepts command beats, computes the frame crc, feeds the queue
// depends on cfb_pkg
module cfb_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  cfb_pkg::cfb_item_t item,
    output logic               q_push,
    output cfb_pkg::cfb_entry_t q_entry,
    input  logic               q_full
);
    import cfb_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cfb_item_t item_reg;
    logic      accept;
    logic [CRC_W-1:0] crc_cmd;

    // stall only while holding a beat the queue cannot take
    assign full   = valid_reg && q_full;
    assign accept = push && !full;

    // hand the held beat to the queue with its checksum
    assign crc_cmd = crc_add_byte(CRC_INIT, item_reg.command_byte);
    assign q_push  = valid_reg;
    assign q_entry = '{command_byte: item_reg.command_byte,
                       payload_byte: item_reg.payload_byte,
                       crc:          crc_add_byte(crc_cmd, item_reg.payload_byte)};

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holding register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

// File: hw/rtl/cfb_queue.sv
// short queue of pending commands between the front and back stages
// depends on cfb_pkg
module cfb_queue
#(
    parameter int unsigned DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  cfb_pkg::cfb_entry_t wr_entry,
    output logic                q_full,
    input  logic                rd_en,
    output cfb_pkg::cfb_entry_t rd_entry,
    output logic                q_empty
);
    import cfb_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfb_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full   = (count_reg == CNT_FULL);
    assign q_empty  = (count_reg == '0);
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && !q_empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// File: hw/rtl/cfb_back.sv
// back stage: serializes one queued command into six frame beats
// depends on cfb_pkg
module cfb_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfb_pkg::cfb_entry_t   q_entry,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [cfb_pkg::BYTE_W-1:0] start_byte,
    input  logic [cfb_pkg::BYTE_W-1:0] stop_byte,
    output logic                  empty,
    input  logic                  pop,
    output cfb_pkg::cfb_result_t  result
);
    import cfb_pkg::*;

    localparam int unsigned IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] BYTE_START = IDX_W'(0);
    localparam logic [IDX_W-1:0] BYTE_CMD   = IDX_W'(1);
    localparam logic [IDX_W-1:0] BYTE_PAY   = IDX_W'(2);
    localparam logic [IDX_W-1:0] BYTE_CRC_H = IDX_W'(3);
    localparam logic [IDX_W-1:0] BYTE_CRC_L = IDX_W'(4);
    localparam logic [IDX_W-1:0] BYTE_STOP  = IDX_W'(FRAME_LEN - 1);

    logic        active_reg;
    logic        active_next;
    cfb_entry_t  entry_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    cfb_result_t out_reg;
    cfb_result_t beat;
    logic        emit;
    logic        take;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // emit a beat whenever the output register is free or draining
    assign emit  = active_reg && (!out_valid_reg || pop);
    assign take  = (!active_reg || (emit && idx_reg == BYTE_STOP)) && !q_empty;
    assign q_pop = take;

    // byte select by position in the frame
    always_comb
    begin
        beat.frame_last = 1'b0;
        unique case (idx_reg)
            BYTE_START: beat.frame_byte = start_byte;
            BYTE_CMD:   beat.frame_byte = entry_reg.command_byte;
            BYTE_PAY:   beat.frame_byte = entry_reg.payload_byte;
            BYTE_CRC_H: beat.frame_byte = entry_reg.crc[CRC_W-1 -: BYTE_W];
            BYTE_CRC_L: beat.frame_byte = entry_reg.crc[BYTE_W-1:0];
            BYTE_STOP:
            begin
                beat.frame_byte = stop_byte;
                beat.frame_last = 1'b1;
            end
            default:    beat.frame_byte = stop_byte;
        endcase
    end

    // sequencer and output register control
    always_comb
    begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + 1'b1;
            if (idx_reg == BYTE_STOP)
            begin
                active_next = 1'b0;
                idx_next    = BYTE_START;
            end
        end
        if (take)
        begin
            active_next = 1'b1;
            idx_next    = BYTE_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= BYTE_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= q_entry;
        end
        if (emit)
        begin
            out_reg <= beat;
        end
    end

endmodule

// File: hw/rtl/command_frame_builder_crc16.sv
// top level of the command frame builder with crc-16/ccitt-false
// depends on cfb_pkg, cfb_front, cfb_queue and cfb_back
//
//  channel   handshake          payload              notes
//  input     push / full        item (cfb_item_t)    one command and payload per beat
//  result    empty / pop        result (cfb_result_t) six beats per command, last flagged
//  config    cfg_we             cfg_index, cfg_data  0 start byte, 1 stop byte
//
// each command produces six result beats, one per cycle while pop is held high,
// so the sustained command rate is set by the back-stage serializer; an input
// beat is registered in the front stage, queue, serializer and output register.
// reset clears the front holding stage, the queue and the serializer and
// restores the start and stop bytes to 0x02 and 0x03.
// a stalled result side fills the queue, after which full rises.
module command_frame_builder_crc16
#(
    parameter int unsigned QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  cfb_pkg::cfb_item_t             item,
    output logic                           empty,
    input  logic                           pop,
    output cfb_pkg::cfb_result_t           result,
    input  logic                           cfg_we,
    input  logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cfb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cfb_pkg::*;

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] stop_byte_reg;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    cfb_entry_t q_wr_entry;
    cfb_entry_t q_rd_entry;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            stop_byte_reg  <= STOP_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data[BYTE_W-1:0];
                CFG_STOP_BYTE:  stop_byte_reg  <= cfg_data[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    cfb_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (q_push),
        .q_entry (q_wr_entry),
        .q_full  (q_full)
    );

    cfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_entry (q_wr_entry),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_entry (q_rd_entry),
        .q_empty  (q_empty)
    );

    cfb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_entry    (q_rd_entry),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .start_byte (start_byte_reg),
        .stop_byte  (stop_byte_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: test/cfb_frame_checker.sv
// frame checker for the command frame builder: watches input, result and register writes
// predicts the six beats of every accepted command and compares them in order
// depends on cfb_pkg
module cfb_frame_checker
    import cfb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  cfb_item_t              item,
    input  logic                   empty,
    input  logic                   pop,
    input  cfb_result_t            result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int unsigned            mismatches,
    output int unsigned            beats_owed
);

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    logic [BYTE_W-1:0] open_value;
    logic [BYTE_W-1:0] close_value;
    cfb_result_t       expected_beats[$];

    // bit-serial crc-16/ccitt-false, msb first
    function automatic logic [CRC_W-1:0] crc_step(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        int               i;
        c = crc ^ {data, 8'h00};
        for (i = 0; i < BYTE_W; i++)
        begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // checksum over command then payload
    function automatic logic [CRC_W-1:0] frame_crc(
        input logic [BYTE_W-1:0] command_byte,
        input logic [BYTE_W-1:0] payload_byte
    );
        return crc_step(crc_step(CRC_INIT, command_byte), payload_byte);
    endfunction

    // expected beats of one frame, appended in send order
    task automatic queue_frame(input cfb_item_t cmd);
        logic [CRC_W-1:0] crc;
        cfb_result_t      beat;
        crc = frame_crc(cmd.command_byte, cmd.payload_byte);
        beat.frame_last = 1'b0;
        beat.frame_byte = open_value;
        expected_beats.push_back(beat);
        beat.frame_byte = cmd.command_byte;
        expected_beats.push_back(beat);
        beat.frame_byte = cmd.payload_byte;
        expected_beats.push_back(beat);
        beat.frame_byte = crc[CRC_W-1 -: BYTE_W];
        expected_beats.push_back(beat);
        beat.frame_byte = crc[BYTE_W-1:0];
        expected_beats.push_back(beat);
        beat.frame_byte = close_value;
        beat.frame_last = 1'b1;
        expected_beats.push_back(beat);
    endtask

    // compare one result beat against the oldest expectation
    task automatic check_beat(input cfb_result_t got);
        cfb_result_t want;
        if (expected_beats.size() == 0)
        begin
            $error("unexpected result beat: frame_byte %0h frame_last %0b",
                   got.frame_byte, got.frame_last);
            mismatches++;
        end
        else
        begin
            want = expected_beats.pop_front();
            if (got.frame_byte !== want.frame_byte)
            begin
                $error("frame_byte mismatch: expected %0h, actual %0h",
                       want.frame_byte, got.frame_byte);
                mismatches++;
            end
            if (got.frame_last !== want.frame_last)
            begin
                $error("frame_last mismatch: expected %0b, actual %0b",
                       want.frame_last, got.frame_last);
                mismatches++;
            end
        end
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_value  = START_BYTE_RESET;
            close_value = STOP_BYTE_RESET;
            expected_beats.delete();
            mismatches  = 0;
            beats_owed  = 0;
        end
        else
        begin
            if (pop && !empty)
                check_beat(result);
            if (push && !full)
                queue_frame(item);
            // indexes other than start and stop are ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_BYTE: open_value  = cfg_data;
                    CFG_STOP_BYTE:  close_value = cfg_data;
                    default:        ;
                endcase
            end
            beats_owed = expected_beats.size();
        end
    end

endmodule

// File: test/tb_command_frame_builder_crc16.sv
// testbench top for command_frame_builder_crc16: clock, reset, stimulus and verdict
// directed framing cases, then random commands under three idling mixes and register settings
// depends on cfb_pkg, command_frame_builder_crc16 and cfb_frame_checker
module tb_command_frame_builder_crc16;

    import cfb_pkg::*;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B  = 2'd3;
    localparam int                     SETTLE_CYCLES = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic                   full;
    cfb_item_t              item      = '0;
    logic                   empty;
    logic                   pop       = 1'b0;
    cfb_result_t            result;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_START_BYTE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned       mismatches;
    int unsigned       beats_owed;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    logic [BYTE_W-1:0] cur_start     = START_BYTE_RESET;
    logic [BYTE_W-1:0] cur_stop      = STOP_BYTE_RESET;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    command_frame_builder_crc16 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfb_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .beats_owed (beats_owed)
    );

    // watchdog
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side stalls at random
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // one command beat, with random idle cycles ahead of it
    task automatic send_command(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] pay);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push              <= 1'b1;
        item.command_byte <= cmd;
        item.payload_byte <= pay;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // stop sending and wait until every frame has come out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (beats_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_START_BYTE)
            cur_start = data;
        else if (idx == CFG_STOP_BYTE)
            cur_stop = data;
    endtask

    // random commands, some carrying the framing values in their data
    task automatic random_commands(input int count);
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] pay;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            cmd  = BYTE_W'($urandom_range(255));
            pay  = BYTE_W'($urandom_range(255));
            pick = $urandom_range(19);
            if (pick == 0)
                cmd = cur_start;
            else if (pick == 1)
                cmd = cur_stop;
            else if (pick == 2)
                pay = cur_start;
            else if (pick == 3)
                pay = cur_stop;
            send_command(cmd, pay);
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] pay;
        logic [CRC_W-1:0]  crc;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // sender rarely idle, receiver mostly stalled
        send_idle_pct = 6;
        recv_idle_pct = 68;

        // field extremes and framing values under reset registers
        send_command(8'h00, 8'h00);
        send_command(8'hFF, 8'hFF);
        send_command(8'h00, 8'hFF);
        send_command(8'hFF, 8'h00);
        send_command(8'hAA, 8'h55);
        send_command(8'h55, 8'hAA);
        send_command(8'h01, 8'h80);
        send_command(8'h80, 8'h01);
        send_command(START_BYTE_RESET, STOP_BYTE_RESET);
        send_command(STOP_BYTE_RESET, START_BYTE_RESET);
        drain();

        // register extremes; writes to spare indexes must change nothing
        write_reg(CFG_START_BYTE, 8'h00);
        write_reg(CFG_STOP_BYTE, 8'hFF);
        write_reg(CFG_SPARE_A, 8'h5A);
        write_reg(CFG_SPARE_B, 8'hA5);
        send_command(8'h00, 8'hFF);
        send_command(8'hFF, 8'h00);
        send_command(8'h00, 8'h00);
        send_command(8'hFF, 8'hFF);
        drain();

        // framing values equal to both crc bytes
        cmd = BYTE_W'($urandom_range(255));
        pay = BYTE_W'($urandom_range(255));
        crc = crc_add_byte(crc_add_byte(CRC_INIT, cmd), pay);
        write_reg(CFG_START_BYTE, crc[CRC_W-1 -: BYTE_W]);
        write_reg(CFG_STOP_BYTE, crc[BYTE_W-1:0]);
        send_command(cmd, pay);
        random_commands(140);
        drain();

        // sender mostly idle, receiver rarely stalled
        send_idle_pct = 68;
        recv_idle_pct = 6;
        write_reg(CFG_START_BYTE, 8'hFF);
        write_reg(CFG_STOP_BYTE, 8'h00);
        random_commands(150);
        drain();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_START_BYTE, CFG_DATA_W'($urandom_range(255)));
        write_reg(CFG_STOP_BYTE, CFG_DATA_W'($urandom_range(255)));
        random_commands(150);
        drain();

        if (mismatches == 0 && beats_owed == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cfb_pkg.sv
hw/rtl/cfb_front.sv
hw/rtl/cfb_queue.sv
hw/rtl/cfb_back.sv
hw/rtl/command_frame_builder_crc16.sv
test/cfb_frame_checker.sv
test/tb_command_frame_builder_crc16.sv
